### rtl/hci_pkg.sv
// ----------------------------------------------------------------------------
// hci_pkg: shared definitions for the haplotype candidate imputer
// Field widths, base codes, operation and status codes, FSM states and the
// base code normalizer used by the position walk.
// ----------------------------------------------------------------------------
package hci_pkg;

	localparam int OP_W     = 2;
	localparam int BASES_W  = 48;
	localparam int LEN_W    = 5;
	localparam int STATUS_W = 2;
	localparam int MIDX_W   = 4;
	localparam int CODE_W   = 3;
	localparam int DIFF_W   = 6;
	localparam int MAX_LEN  = 16;

	localparam logic [CODE_W-1:0] CODE_N     = 3'd4;
	localparam logic [CODE_W-1:0] CODE_OTHER = 3'd5;
	localparam logic [CODE_W-1:0] CODE_PAD   = 3'd7;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_IMPUTE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_MATCH    = 2'd0,
		ST_NO_MATCH = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINAL
	} state_t;

	// Pad past the end of a string, fold unused codes onto "other".
	function automatic logic [CODE_W-1:0] code_norm(
		input logic [CODE_W-1:0] raw,
		input logic [LEN_W-1:0]  pos,
		input logic [LEN_W-1:0]  len
	);
		logic [CODE_W-1:0] c;
		if (pos >= len) begin
			c = CODE_PAD;
		end else if (raw > CODE_OTHER) begin
			c = CODE_OTHER;
		end else begin
			c = raw;
		end
		return c;
	endfunction

endpackage

### rtl/hci_if.sv
// ----------------------------------------------------------------------------
// hci_if: channel interfaces of the haplotype candidate imputer
// Command, response and configuration channels, each a valid/ready pair
// with its payload.
// ----------------------------------------------------------------------------
interface hci_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [hci_pkg::OP_W-1:0]    op;
	logic [hci_pkg::BASES_W-1:0] bases;
	logic [hci_pkg::LEN_W-1:0]   length;

	modport source (output valid, op, bases, length, input ready);
	modport sink   (input valid, op, bases, length, output ready);
endinterface

interface hci_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [hci_pkg::STATUS_W-1:0] status;
	logic [hci_pkg::MIDX_W-1:0]   match_index;
	logic [hci_pkg::BASES_W-1:0]  matched_bases;
	logic [hci_pkg::LEN_W-1:0]    matched_length;

	modport source (output valid, status, match_index, matched_bases, matched_length,
		input ready);
	modport sink   (input valid, status, match_index, matched_bases, matched_length,
		output ready);
endinterface

interface hci_cfg_if;
	logic valid;
	logic ready;
	logic uniq_mode;

	modport source (output valid, uniq_mode, input ready);
	modport sink   (input valid, uniq_mode, output ready);
endinterface

### rtl/haplotype_candidate_imputer.sv
// ----------------------------------------------------------------------------
// haplotype_candidate_imputer: catalog lookup of a haplotype by position walk
// Keeps up to MAX_HAPS haplotypes and imputes a query to the one catalog
// entry that survives a position-by-position filter and a final check.
// ----------------------------------------------------------------------------
// Clear (op 0) and append (op 1) return nothing; an append to a full
// catalog is dropped. An impute (op 2) walks L positions, where L is the
// larger of the query length and catalog slot 0's length (saturated to 16):
// each catalog slot has its own lane that shifts one 3-bit base code per
// cycle past a shared query code, and the final state then selects the
// lone survivor into the response register. An empty catalog skips the
// walk and goes straight to the final state. The response register frees
// the walk from the downstream side: a new command is taken while an
// earlier response still waits, and an impute only holds in its final
// cycle if that response has not yet left. uniq_mode is written through
// the cfg channel, which is always ready, and must only change while no
// impute is in flight.
// ----------------------------------------------------------------------------
module haplotype_candidate_imputer #(
	parameter int MAX_HAPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	hci_cfg_if.sink      cfg,
	hci_cmd_if.sink      cmd,
	hci_rsp_if.source    rsp
);

	localparam int IDX_W = (MAX_HAPS > 1) ? $clog2(MAX_HAPS) : 1;
	localparam int CNT_W = $clog2(MAX_HAPS + 1);

	// catalog storage, one row per lane
	logic [hci_pkg::BASES_W-1:0] store_q [MAX_HAPS];
	logic [hci_pkg::LEN_W-1:0]   slen_q  [MAX_HAPS];
	logic [CNT_W-1:0]            cnt_q;

	// per-lane walk state
	logic [hci_pkg::BASES_W-1:0] work_q  [MAX_HAPS];
	logic [hci_pkg::DIFF_W-1:0]  diff_q  [MAX_HAPS];
	logic [MAX_HAPS-1:0]         alive_q;
	logic [MAX_HAPS-1:0]         mism_q;

	// query walk state
	hci_pkg::state_t             state_q, state_d;
	logic [hci_pkg::BASES_W-1:0] qbases_q;
	logic [hci_pkg::LEN_W-1:0]   qlen_q;
	logic [hci_pkg::LEN_W-1:0]   maxlen_q;
	logic [hci_pkg::LEN_W-1:0]   pos_q;
	logic                        empty_q;
	logic                        uniq_q;

	// response register
	logic                         out_valid_q;
	logic [hci_pkg::STATUS_W-1:0] status_q;
	logic [hci_pkg::MIDX_W-1:0]   midx_q;
	logic [hci_pkg::BASES_W-1:0]  mbases_q;
	logic [hci_pkg::LEN_W-1:0]    mlen_q;

	logic                         cmd_fire;
	hci_pkg::op_t                 cmd_op;
	logic [hci_pkg::LEN_W-1:0]    len_sat;
	logic [hci_pkg::LEN_W-1:0]    maxlen_start;
	logic                         walk_skip;
	logic [hci_pkg::CODE_W-1:0]   qc;
	logic                         q_is_n;
	logic [hci_pkg::CODE_W-1:0]   cc      [MAX_HAPS];
	logic [MAX_HAPS-1:0]          lane_eq;
	logic [MAX_HAPS-1:0]          keep;
	logic                         multi;
	logic                         walk_last;
	logic                         out_free;
	logic                         final_load;

	logic                         sel_mism;
	logic                         sel_diff_zero;
	logic [hci_pkg::BASES_W-1:0]  sel_bases;
	logic [hci_pkg::LEN_W-1:0]    sel_len;
	logic [IDX_W-1:0]             sel_slot;
	logic [IDX_W+hci_pkg::MIDX_W-1:0] slot_ext;
	logic                         match_ok;

	assign cfg.ready = 1'b1;
	assign cmd_op    = hci_pkg::op_t'(cmd.op);
	assign cmd_fire  = cmd.valid && cmd.ready;

	// lengths above the supported maximum saturate
	assign len_sat = (cmd.length > hci_pkg::LEN_W'(hci_pkg::MAX_LEN))
		? hci_pkg::LEN_W'(hci_pkg::MAX_LEN) : cmd.length;

	// walk length: longer of the query and catalog slot 0
	assign maxlen_start = (len_sat > slen_q[0]) ? len_sat : slen_q[0];
	assign walk_skip    = (cnt_q == '0) || (maxlen_start == '0);

	// query code at the current position comes out of the low digit
	assign qc     = hci_pkg::code_norm(qbases_q[hci_pkg::CODE_W-1:0], pos_q, qlen_q);
	assign q_is_n = (qc == hci_pkg::CODE_N);

	always_comb begin
		for (int k = 0; k < MAX_HAPS; k++) begin
			cc[k]      = hci_pkg::code_norm(work_q[k][hci_pkg::CODE_W-1:0], pos_q, slen_q[k]);
			lane_eq[k] = (cc[k] == qc);
			keep[k]    = lane_eq[k] || (uniq_q && q_is_n);
		end
	end

	// more than one survivor: clearing the lowest set bit leaves something
	assign multi     = |(alive_q & (alive_q - MAX_HAPS'(1)));
	assign walk_last = ((pos_q + hci_pkg::LEN_W'(1)) == maxlen_q);

	// alive is one-hot when it matters, so an OR over lanes selects the survivor
	always_comb begin
		sel_mism      = 1'b0;
		sel_diff_zero = 1'b0;
		sel_bases     = '0;
		sel_len       = '0;
		sel_slot      = '0;
		for (int k = 0; k < MAX_HAPS; k++) begin
			sel_mism      = sel_mism | (alive_q[k] & mism_q[k]);
			sel_diff_zero = sel_diff_zero | (alive_q[k] & (diff_q[k] == '0));
			sel_bases     = sel_bases | ({hci_pkg::BASES_W{alive_q[k]}} & store_q[k]);
			sel_len       = sel_len | ({hci_pkg::LEN_W{alive_q[k]}} & slen_q[k]);
			sel_slot      = sel_slot | (alive_q[k] ? IDX_W'(k) : '0);
		end
	end

	assign slot_ext = {{hci_pkg::MIDX_W{1'b0}}, sel_slot};
	assign match_ok = (alive_q != '0) && !multi && (uniq_q ? sel_diff_zero : !sel_mism);

	assign out_free   = !out_valid_q || rsp.ready;

	// next state and handshake
	always_comb begin
		state_d    = state_q;
		cmd.ready  = 1'b0;
		final_load = 1'b0;
		unique case (state_q)
			hci_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid && cmd_op == hci_pkg::OP_IMPUTE) begin
					state_d = walk_skip ? hci_pkg::S_FINAL : hci_pkg::S_WALK;
				end
			end
			hci_pkg::S_WALK: begin
				if (walk_last) begin
					state_d = hci_pkg::S_FINAL;
				end
			end
			hci_pkg::S_FINAL: begin
				if (out_free) begin
					final_load = 1'b1;
					state_d    = hci_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = hci_pkg::S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hci_pkg::S_IDLE;
			cnt_q       <= '0;
			uniq_q      <= 1'b0;
			alive_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				uniq_q <= cfg.uniq_mode;
			end
			if (cmd_fire) begin
				unique case (cmd_op)
					hci_pkg::OP_CLEAR: begin
						cnt_q <= '0;
					end
					hci_pkg::OP_APPEND: begin
						if (cnt_q < CNT_W'(MAX_HAPS)) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					hci_pkg::OP_IMPUTE: begin
						for (int k = 0; k < MAX_HAPS; k++) begin
							alive_q[k] <= (CNT_W'(k) < cnt_q);
						end
					end
					default: begin
					end
				endcase
			end
			// drop mismatching candidates only while several survive
			if (state_q == hci_pkg::S_WALK && multi) begin
				alive_q <= alive_q & keep;
			end
			if (final_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// catalog rows and lane datapath
	always_ff @(posedge clk) begin
		if (cmd_fire && cmd_op == hci_pkg::OP_APPEND && cnt_q < CNT_W'(MAX_HAPS)) begin
			for (int k = 0; k < MAX_HAPS; k++) begin
				if (cnt_q == CNT_W'(k)) begin
					store_q[k] <= cmd.bases;
					slen_q[k]  <= len_sat;
				end
			end
		end
		if (cmd_fire && cmd_op == hci_pkg::OP_IMPUTE) begin
			qbases_q <= cmd.bases;
			qlen_q   <= len_sat;
			maxlen_q <= maxlen_start;
			pos_q    <= '0;
			empty_q  <= (cnt_q == '0);
			for (int k = 0; k < MAX_HAPS; k++) begin
				work_q[k] <= store_q[k];
				mism_q[k] <= 1'b0;
				diff_q[k] <= '0;
			end
		end else if (state_q == hci_pkg::S_WALK) begin
			// advance one code; zeros shift in above the packed field
			qbases_q <= qbases_q >> hci_pkg::CODE_W;
			pos_q    <= pos_q + hci_pkg::LEN_W'(1);
			for (int k = 0; k < MAX_HAPS; k++) begin
				work_q[k] <= work_q[k] >> hci_pkg::CODE_W;
				mism_q[k] <= mism_q[k] | !lane_eq[k];
				// running (equal positions) - (query positions not N)
				if (lane_eq[k] && q_is_n) begin
					diff_q[k] <= diff_q[k] + hci_pkg::DIFF_W'(1);
				end else if (!lane_eq[k] && !q_is_n) begin
					diff_q[k] <= diff_q[k] - hci_pkg::DIFF_W'(1);
				end
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (final_load) begin
			if (empty_q) begin
				status_q <= hci_pkg::ST_EMPTY;
				midx_q   <= '0;
				mbases_q <= '0;
				mlen_q   <= '0;
			end else if (match_ok) begin
				status_q <= hci_pkg::ST_MATCH;
				midx_q   <= slot_ext[hci_pkg::MIDX_W-1:0];
				mbases_q <= sel_bases;
				mlen_q   <= sel_len;
			end else begin
				status_q <= hci_pkg::ST_NO_MATCH;
				midx_q   <= '0;
				mbases_q <= '0;
				mlen_q   <= '0;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.match_index    = midx_q;
	assign rsp.matched_bases  = mbases_q;
	assign rsp.matched_length = mlen_q;

endmodule
